FILE: design/tor_pkg.sv
package tor_pkg;

    localparam int VIEW_SIZE_DEF       = 256;
    localparam int SUBPIXEL_BITS_DEF   = 4;
    localparam int DEPTH_FRAC_BITS_DEF = 16;
    localparam int COUNT_WIDTH_DEF     = 16;

    localparam int COORD_W  = 13;
    localparam int ZIN_W    = 25;
    localparam int TOTAL_W  = 32;
    localparam int PASSED_W = 17;
    localparam int ZST_W    = 26;
    localparam int PIX_W    = 14;

    typedef enum logic [1:0] {
        ACT_DRAW      = 2'd0,
        ACT_CLEAR     = 2'd1,
        ACT_CLEAR_ALL = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [COORD_W-1:0]   ax;
        logic [COORD_W-1:0]   ay;
        logic [ZIN_W-1:0]     az;
        logic [COORD_W-1:0]   bx;
        logic [COORD_W-1:0]   by_coord;
        logic [ZIN_W-1:0]     bz;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [ZIN_W-1:0]     cz;
    } t_in_item;

    typedef struct packed {
        logic [TOTAL_W-1:0]  covered_total;
        logic [TOTAL_W-1:0]  shaded_total;
        logic [PASSED_W-1:0] passed_here;
        logic                back_layer;
    } t_out_item;

endpackage

FILE: design/tor_ifs.sv
interface tor_in_if;
    logic               valid;
    logic               ready;
    tor_pkg::t_in_item  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tor_out_if;
    logic               valid;
    logic               ready;
    tor_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/tor_ram.sv
module tor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

FILE: design/triangle_overdraw_rasterizer.sv
// Draw items first run a setup on the one shared multiplier, then walk the
// box pixel by pixel: a pixel that misses the triangle is skipped, and each
// covered pixel of a triangle that is not degenerate also goes through the
// shared restoring divider, which divides the perspective-free depth bit by bit.
// Clear items sweep both pixel layers, and the same sweep runs after reset
// before the first item is taken. The result of every item is held until it
// is taken; the next item is taken after that.
module triangle_overdraw_rasterizer #(
    parameter int VIEW_SIZE       = tor_pkg::VIEW_SIZE_DEF,
    parameter int SUBPIXEL_BITS   = tor_pkg::SUBPIXEL_BITS_DEF,
    parameter int DEPTH_FRAC_BITS = tor_pkg::DEPTH_FRAC_BITS_DEF,
    parameter int COUNT_WIDTH     = tor_pkg::COUNT_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tor_in_if.sink    i_in,
    tor_out_if.source o_out
);

    localparam int MEM_DEPTH = 2 * VIEW_SIZE * VIEW_SIZE;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int MEM_W     = tor_pkg::ZST_W + COUNT_WIDTH;
    localparam int PW        = tor_pkg::PIX_W;
    localparam int CW        = tor_pkg::COORD_W;
    localparam int ZW        = tor_pkg::ZST_W;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_SETUP = 9'b000000100,
        S_PIX   = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_RD    = 9'b000100000,
        S_CMP   = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_reply;

    logic [31:0] r_cov, r_shd;
    logic [16:0] r_passed;
    logic        r_layer;
    logic        r_neg;

    logic [CW-1:0]          r_vx [3];
    logic [CW-1:0]          r_vy [3];
    logic [tor_pkg::ZIN_W-1:0] r_z1;
    logic signed [13:0]     r_d21x, r_d21y, r_d31x, r_d31y;
    logic signed [25:0]     r_dz21, r_dz31;
    logic [PW-1:0]          r_mnx, r_mxx, r_mny, r_mxy, r_px, r_py;

    logic [3:0]             r_step;
    logic signed [63:0]     r_prod, r_acc;
    logic [27:0]            r_det;
    logic signed [41:0]     r_nx, r_ny;
    logic signed [39:0]     r_e [3];
    logic signed [39:0]     r_erow [3];
    logic signed [63:0]     r_n, r_nrow;
    logic [ADDR_W-1:0]      r_addr, r_row_addr;

    logic [63:0]            r_dq;
    logic [28:0]            r_rem;
    logic [5:0]             r_cnt;
    logic                   r_nneg;
    logic signed [ZW-1:0]   r_z;

    // box from the vertices of the incoming item
    function automatic logic [CW-1:0] min3(logic [CW-1:0] a, logic [CW-1:0] b,
                                           logic [CW-1:0] c);
        logic [CW-1:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic logic [CW-1:0] max3(logic [CW-1:0] a, logic [CW-1:0] b,
                                           logic [CW-1:0] c);
        logic [CW-1:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

    function automatic logic [PW-1:0] ceil_pix(logic [CW-1:0] v);
        logic [CW:0] s;
        s = {1'b0, v} + (CW+1)'((1 << SUBPIXEL_BITS) - 1);
        return PW'(s >> SUBPIXEL_BITS);
    endfunction

    function automatic logic [PW-1:0] clip_view(logic [PW-1:0] v);
        return (v > PW'(VIEW_SIZE)) ? PW'(VIEW_SIZE) : v;
    endfunction

    tor_pkg::t_in_item w_in;
    assign w_in = i_in.data;

    // edge deltas of the (possibly swapped) vertices
    logic signed [13:0] w_dx [3];
    logic signed [13:0] w_dy [3];
    logic signed [15:0] w_bxd [3];
    logic signed [15:0] w_byd [3];
    logic [2:0]         w_tl;
    logic signed [39:0] w_dxs [3];
    logic signed [39:0] w_dys [3];
    logic [15:0]        w_sx0, w_sy0;

    assign w_sx0 = 16'(r_mnx) << SUBPIXEL_BITS;
    assign w_sy0 = 16'(r_mny) << SUBPIXEL_BITS;

    always_comb begin
        for (int e = 0; e < 3; e++) begin
            w_dx[e]  = 14'(r_vx[e]) - 14'(r_vx[(e + 1) % 3]);
            w_dy[e]  = 14'(r_vy[e]) - 14'(r_vy[(e + 1) % 3]);
            w_bxd[e] = w_sx0 - 16'(r_vx[e]);
            w_byd[e] = w_sy0 - 16'(r_vy[e]);
            w_tl[e]  = (w_dy[e] < 0) || (w_dy[e] == 0 && w_dx[e] > 0);
            w_dxs[e] = {{26{w_dx[e][13]}}, w_dx[e]} <<< SUBPIXEL_BITS;
            w_dys[e] = {{26{w_dy[e][13]}}, w_dy[e]} <<< SUBPIXEL_BITS;
        end
    end

    // shared multiplier
    logic signed [41:0] w_ma;
    logic signed [15:0] w_mb;
    logic signed [57:0] w_full;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_step)
            4'd0:  begin w_ma = 42'(r_d21x); w_mb = 16'(r_d31y); end
            4'd1:  begin w_ma = 42'(r_d21y); w_mb = 16'(r_d31x); end
            4'd2:  begin w_ma = 42'(r_dz21); w_mb = 16'(r_d31y); end
            4'd3:  begin w_ma = 42'(r_dz31); w_mb = 16'(r_d21y); end
            4'd4:  begin w_ma = 42'(r_dz31); w_mb = 16'(r_d21x); end
            4'd5:  begin w_ma = 42'(r_dz21); w_mb = 16'(r_d31x); end
            4'd6:  begin w_ma = 42'(w_dx[0]); w_mb = w_byd[0]; end
            4'd7:  begin w_ma = 42'(w_dy[0]); w_mb = w_bxd[0]; end
            4'd8:  begin w_ma = 42'(w_dx[1]); w_mb = w_byd[1]; end
            4'd9:  begin w_ma = 42'(w_dy[1]); w_mb = w_bxd[1]; end
            4'd10: begin w_ma = 42'(w_dx[2]); w_mb = w_byd[2]; end
            4'd11: begin w_ma = 42'(w_dy[2]); w_mb = w_bxd[2]; end
            4'd12: begin w_ma = r_nx; w_mb = w_bxd[0]; end
            4'd13: begin w_ma = r_ny; w_mb = w_byd[0]; end
            4'd14: begin w_ma = $signed({28'b0, r_mny}); w_mb = 16'(VIEW_SIZE); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_full = w_ma * w_mb;

    // accumulate the product of the previous step
    logic signed [63:0] w_val;
    always_comb begin
        if (r_step[0] == 1'b1 || r_step == 4'd15) begin
            w_val = r_prod;
        end else if (r_step == 4'd14) begin
            w_val = r_acc + r_prod;
        end else begin
            w_val = r_acc - r_prod;
        end
    end

    logic signed [63:0] w_nxs, w_nys;
    assign w_nxs = {{22{r_nx[41]}}, r_nx} <<< (SUBPIXEL_BITS + 1);
    assign w_nys = {{22{r_ny[41]}}, r_ny} <<< (SUBPIXEL_BITS + 1);

    // divider step
    logic [29:0] w_rsh;
    logic        w_qbit;
    logic [29:0] w_rnew;
    assign w_rsh  = {r_rem, r_dq[63]};
    assign w_qbit = w_rsh >= {1'b0, r_det, 1'b0};
    assign w_rnew = w_qbit ? (w_rsh - {1'b0, r_det, 1'b0}) : w_rsh;

    // floored quotient to clamped depth
    logic signed [67:0] w_q, w_zr;
    logic signed [ZW-1:0] w_z;
    always_comb begin
        w_q = $signed({4'b0, r_dq});
        if (r_nneg) begin
            w_q = -w_q - ((r_rem != '0) ? 68'sd1 : 68'sd0);
        end
        w_zr = $signed({43'b0, r_z1}) + w_q;
        if (r_layer) begin
            w_zr = ($signed(68'(VIEW_SIZE)) <<< DEPTH_FRAC_BITS) - w_zr;
        end
        if (w_zr > 68'sd33554431) begin
            w_z = 26'sd33554431;
        end else if (w_zr < -68'sd33554432) begin
            w_z = -26'sd33554432;
        end else begin
            w_z = w_zr[ZW-1:0];
        end
    end

    // pixel store
    logic                    w_we;
    logic [ADDR_W-1:0]       w_addr;
    logic [MEM_W-1:0]        w_wdata, w_rdata;
    logic signed [ZW-1:0]    w_old_z;
    logic [COUNT_WIDTH-1:0]  w_old_cnt;
    logic                    w_pass;

    assign w_old_z   = w_rdata[ZW-1:0];
    assign w_old_cnt = w_rdata[MEM_W-1:ZW];
    assign w_pass    = (r_state == S_CMP) && (r_z >= w_old_z);
    assign w_we      = (r_state == S_CLEAR) || w_pass;
    assign w_addr    = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_wdata   = (r_state == S_CLEAR) ? '0 :
                       {((w_old_cnt == '1) ? w_old_cnt : w_old_cnt + 1'b1), r_z};

    tor_ram #(.WIDTH(MEM_W), .DEPTH(MEM_DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    logic w_hit;
    assign w_hit = !r_e[0][39] && !r_e[1][39] && !r_e[2][39];

    // edge written during setup
    logic [1:0] w_eidx;
    assign w_eidx = 2'((r_step - 4'd8) >> 1);

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data  = '{covered_total: r_cov, shaded_total: r_shd,
                           passed_here: r_passed, back_layer: r_layer};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_reply <= 1'b0;
            r_cov       <= '0;
            r_shd       <= '0;
            r_passed    <= '0;
            r_layer     <= 1'b0;
        end else begin
            r_prod <= {{6{w_full[57]}}, w_full};
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                        r_clr_addr <= '0;
                        r_state    <= r_clr_reply ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_passed <= '0;
                        r_layer  <= 1'b0;
                        r_vx[0] <= w_in.ax; r_vx[1] <= w_in.bx; r_vx[2] <= w_in.cx;
                        r_vy[0] <= w_in.ay; r_vy[1] <= w_in.by_coord; r_vy[2] <= w_in.cy;
                        r_z1   <= w_in.az;
                        r_d21x <= 14'(w_in.bx) - 14'(w_in.ax);
                        r_d31x <= 14'(w_in.cx) - 14'(w_in.ax);
                        r_d21y <= 14'(w_in.by_coord) - 14'(w_in.ay);
                        r_d31y <= 14'(w_in.cy) - 14'(w_in.ay);
                        r_dz21 <= 26'(w_in.bz) - 26'(w_in.az);
                        r_dz31 <= 26'(w_in.cz) - 26'(w_in.az);
                        r_mnx <= ceil_pix(min3(w_in.ax, w_in.bx, w_in.cx));
                        r_mny <= ceil_pix(min3(w_in.ay, w_in.by_coord, w_in.cy));
                        r_mxx <= clip_view(ceil_pix(max3(w_in.ax, w_in.bx, w_in.cx)));
                        r_mxy <= clip_view(ceil_pix(max3(w_in.ay, w_in.by_coord, w_in.cy)));
                        r_px  <= ceil_pix(min3(w_in.ax, w_in.bx, w_in.cx));
                        r_py  <= ceil_pix(min3(w_in.ay, w_in.by_coord, w_in.cy));
                        r_step <= '0;
                        case (w_in.action)
                            tor_pkg::ACT_DRAW: r_state <= S_SETUP;
                            tor_pkg::ACT_CLEAR: begin
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLEAR;
                            end
                            tor_pkg::ACT_CLEAR_ALL: begin
                                r_clr_reply <= 1'b1;
                                r_cov       <= '0;
                                r_shd       <= '0;
                                r_state     <= S_CLEAR;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_step <= r_step + 1'b1;
                    r_acc  <= w_val;
                    case (r_step)
                        4'd2: begin
                            r_det   <= 28'((w_val < 0) ? -w_val : w_val);
                            r_neg   <= w_val < 0;
                            r_layer <= w_val > 0;
                            if (w_val > 0) begin
                                r_vx[1] <= r_vx[2]; r_vx[2] <= r_vx[1];
                                r_vy[1] <= r_vy[2]; r_vy[2] <= r_vy[1];
                            end
                        end
                        4'd4: r_nx <= 42'(r_neg ? -w_val : w_val);
                        4'd6: r_ny <= 42'(r_neg ? -w_val : w_val);
                        4'd8, 4'd10, 4'd12: begin
                            r_e[w_eidx]    <= 40'(w_val) -
                                (w_tl[w_eidx] ? 40'sd0 : 40'sd1);
                            r_erow[w_eidx] <= 40'(w_val) -
                                (w_tl[w_eidx] ? 40'sd0 : 40'sd1);
                        end
                        4'd14: begin
                            r_n    <= (w_val <<< 1) + $signed({36'b0, r_det});
                            r_nrow <= (w_val <<< 1) + $signed({36'b0, r_det});
                        end
                        4'd15: begin
                            r_row_addr <= ADDR_W'(w_val) + ADDR_W'(r_mnx) +
                                (r_layer ? ADDR_W'(VIEW_SIZE * VIEW_SIZE) : '0);
                            r_addr     <= ADDR_W'(w_val) + ADDR_W'(r_mnx) +
                                (r_layer ? ADDR_W'(VIEW_SIZE * VIEW_SIZE) : '0);
                            r_state <= (r_mnx < r_mxx && r_mny < r_mxy) ? S_PIX : S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_PIX: begin
                    if (!w_hit) begin
                        r_state <= S_NEXT;
                    end else if (r_det == '0) begin
                        r_dq    <= '0;
                        r_rem   <= '0;
                        r_nneg  <= 1'b0;
                        r_state <= S_RD;
                    end else begin
                        r_dq    <= 64'((r_n < 0) ? -r_n : r_n);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_nneg  <= r_n < 0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= w_rnew[28:0];
                    r_dq  <= {r_dq[62:0], w_qbit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_z     <= w_z;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (w_pass) begin
                        if (w_old_cnt == '0 && r_cov != '1) r_cov <= r_cov + 1'b1;
                        if (r_shd != '1) r_shd <= r_shd + 1'b1;
                        if (r_passed != '1) r_passed <= r_passed + 1'b1;
                    end
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_px + 1'b1 < r_mxx) begin
                        r_px   <= r_px + 1'b1;
                        r_addr <= r_addr + 1'b1;
                        r_n    <= r_n + w_nxs;
                        for (int e = 0; e < 3; e++) r_e[e] <= r_e[e] - w_dys[e];
                        r_state <= S_PIX;
                    end else if (r_py + 1'b1 < r_mxy) begin
                        r_py       <= r_py + 1'b1;
                        r_px       <= r_mnx;
                        r_row_addr <= r_row_addr + ADDR_W'(VIEW_SIZE);
                        r_addr     <= r_row_addr + ADDR_W'(VIEW_SIZE);
                        r_nrow     <= r_nrow + w_nys;
                        r_n        <= r_nrow + w_nys;
                        for (int e = 0; e < 3; e++) begin
                            r_erow[e] <= r_erow[e] + w_dxs[e];
                            r_e[e]    <= r_erow[e] + w_dxs[e];
                        end
                        r_state <= S_PIX;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_clr_reply <= 1'b0;
                    if (o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: tb/tor_ifs_tb.sv
package tor_tb_pkg;

    localparam int CRD_W = tor_pkg::COORD_W;
    localparam int DEP_W = tor_pkg::ZIN_W;

    function automatic tor_pkg::t_in_item make_tri(int x1, int y1, int z1,
                                                   int x2, int y2, int z2,
                                                   int x3, int y3, int z3);
        tor_pkg::t_in_item it;
        it.action   = tor_pkg::ACT_DRAW;
        it.ax       = CRD_W'(x1);
        it.ay       = CRD_W'(y1);
        it.az       = DEP_W'(z1);
        it.bx       = CRD_W'(x2);
        it.by_coord = CRD_W'(y2);
        it.bz       = DEP_W'(z2);
        it.cx       = CRD_W'(x3);
        it.cy       = CRD_W'(y3);
        it.cz       = DEP_W'(z3);
        return it;
    endfunction
endpackage

FILE: tb/testbench.sv
module testbench;

    localparam int VSZ    = tor_pkg::VIEW_SIZE_DEF;
    localparam int SUB    = tor_pkg::SUBPIXEL_BITS_DEF;
    localparam int DFRAC  = tor_pkg::DEPTH_FRAC_BITS_DEF;
    localparam int CWID   = tor_pkg::COUNT_WIDTH_DEF;
    localparam int CRDW   = tor_pkg::COORD_W;
    localparam int ZINW   = tor_pkg::ZIN_W;
    localparam int PASW   = tor_pkg::PASSED_W;
    localparam int NPIX   = 2 * VSZ * VSZ;
    localparam int NRAND  = 1530;

    logic i_clk;
    logic i_rst_n;

    tor_in_if  in_if();
    tor_out_if out_if();

    triangle_overdraw_rasterizer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // shadow of the pixel stores and totals
    int          depth_mem [NPIX];
    int unsigned hits_mem  [NPIX];
    int unsigned covered_sum;
    int unsigned shaded_sum;

    tor_pkg::t_in_item  triangle_q [$];
    tor_pkg::t_out_item totals_q   [$];
    int        n_fail;
    bit        beat_taken;
    int        gap_left;
    int        burst_left;
    int        stall_left;
    int        run_left;

    function automatic longint edge_fn(longint xi, longint yi, longint xj, longint yj,
                                       longint sx, longint sy);
        longint dx, dy, tl;
        dx = xi - xj;
        dy = yi - yj;
        tl = (dy < 0 || (dy == 0 && dx > 0)) ? 1 : 0;
        return dx * (sy - yi) - dy * (sx - xi) + tl - 1;
    endfunction

    function automatic tor_pkg::t_out_item shade_triangle(tor_pkg::t_in_item it);
        tor_pkg::t_out_item r;
        longint x1, y1, z1, x2, y2, z2, x3, y3, z3, det, nx, ny, t;
        longint mnx, mxx, mny, mxy, px, py, sx, sy, z, num, den, q;
        int unsigned passed;
        int idx;
        bit layer;
        passed = 0;
        layer  = 1'b0;
        if (it.action == tor_pkg::ACT_CLEAR || it.action == tor_pkg::ACT_CLEAR_ALL) begin
            for (int i = 0; i < NPIX; i++) begin
                depth_mem[i] = 0;
                hits_mem[i]  = 0;
            end
            if (it.action == tor_pkg::ACT_CLEAR_ALL) begin
                covered_sum = 0;
                shaded_sum  = 0;
            end
        end else if (it.action == tor_pkg::ACT_DRAW) begin
            x1 = it.ax; y1 = it.ay; z1 = it.az;
            x2 = it.bx; y2 = it.by_coord; z2 = it.bz;
            x3 = it.cx; y3 = it.cy; z3 = it.cz;
            det = (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
            nx  = (z2 - z1) * (y3 - y1) - (y2 - y1) * (z3 - z1);
            ny  = (x2 - x1) * (z3 - z1) - (z2 - z1) * (x3 - x1);
            layer = det > 0;
            if (det < 0) begin
                det = -det; nx = -nx; ny = -ny;
            end
            if (layer) begin
                t = x2; x2 = x3; x3 = t;
                t = y2; y2 = y3; y3 = t;
            end
            mnx = x1 < x2 ? x1 : x2; mnx = x3 < mnx ? x3 : mnx;
            mxx = x1 > x2 ? x1 : x2; mxx = x3 > mxx ? x3 : mxx;
            mny = y1 < y2 ? y1 : y2; mny = y3 < mny ? y3 : mny;
            mxy = y1 > y2 ? y1 : y2; mxy = y3 > mxy ? y3 : mxy;
            mnx = (mnx + (1 << SUB) - 1) >>> SUB;
            mxx = (mxx + (1 << SUB) - 1) >>> SUB;
            mny = (mny + (1 << SUB) - 1) >>> SUB;
            mxy = (mxy + (1 << SUB) - 1) >>> SUB;
            if (mxx > VSZ) mxx = VSZ;
            if (mxy > VSZ) mxy = VSZ;
            for (py = mny; py < mxy; py++) begin
                for (px = mnx; px < mxx; px++) begin
                    sx = px << SUB;
                    sy = py << SUB;
                    if (edge_fn(x1, y1, x2, y2, sx, sy) < 0 ||
                        edge_fn(x2, y2, x3, y3, sx, sy) < 0 ||
                        edge_fn(x3, y3, x1, y1, sx, sy) < 0)
                        continue;
                    z = z1;
                    if (det != 0) begin
                        num = 2 * (nx * (sx - x1) + ny * (sy - y1)) + det;
                        den = 2 * det;
                        q = num / den;
                        if (num % den != 0 && num < 0) q = q - 1;
                        z = z + q;
                    end
                    if (layer) z = (longint'(VSZ) << DFRAC) - z;
                    if (z > 33554431) z = 33554431;
                    if (z < -33554432) z = -33554432;
                    idx = int'(layer) * VSZ * VSZ + int'(py) * VSZ + int'(px);
                    if (z >= depth_mem[idx]) begin
                        depth_mem[idx] = int'(z);
                        if (hits_mem[idx] == 0 && covered_sum != 32'hFFFF_FFFF)
                            covered_sum++;
                        if (hits_mem[idx] < (1 << CWID) - 1)
                            hits_mem[idx]++;
                        if (shaded_sum != 32'hFFFF_FFFF)
                            shaded_sum++;
                        if (passed < 32'h1FFFF)
                            passed++;
                    end
                end
            end
        end
        r.covered_total = covered_sum;
        r.shaded_total  = shaded_sum;
        r.passed_here   = PASW'(passed);
        r.back_layer    = layer;
        return r;
    endfunction

    function automatic tor_pkg::t_in_item random_triangle();
        tor_pkg::t_in_item it;
        int kind, bx0, by0, span;
        it = tor_tb_pkg::make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);
        it.az = ZINW'($urandom);
        it.bz = ZINW'($urandom);
        it.cz = ZINW'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            // close depths so layers fight over the same pixels
            it.bz = it.az + ZINW'($urandom_range(0, 4000)) - ZINW'(2000);
            it.cz = it.az + ZINW'($urandom_range(0, 4000)) - ZINW'(2000);
        end
        kind = $urandom_range(0, 99);
        span = (kind < 80) ? 48 : 160;
        bx0  = $urandom_range(0, 12) * 16 + $urandom_range(0, 15);
        by0  = $urandom_range(0, 12) * 16 + $urandom_range(0, 15);
        if (kind >= 90 && kind < 95) begin
            // near the far corner, clipped against the view
            bx0 = $urandom_range(3990, 4096);
            by0 = $urandom_range(3990, 4096);
            span = 120;
        end
        it.ax = CRDW'(bx0 + $urandom_range(0, span));
        it.ay = CRDW'(by0 + $urandom_range(0, span));
        it.bx = CRDW'(bx0 + $urandom_range(0, span));
        it.by_coord = CRDW'(by0 + $urandom_range(0, span));
        it.cx = CRDW'(bx0 + $urandom_range(0, span));
        it.cy = CRDW'(by0 + $urandom_range(0, span));
        if (kind >= 95 && kind < 98) begin
            // entirely right of the view: empty box, any high bits
            it.ax = CRDW'($urandom) | 13'h1000;
            it.bx = CRDW'($urandom) | 13'h1000;
            it.cx = CRDW'($urandom) | 13'h1000;
            it.ay = CRDW'($urandom);
            it.by_coord = CRDW'($urandom);
            it.cy = CRDW'($urandom);
        end else if (kind >= 98) begin
            // degenerate: two vertices on top of each other
            it.cx = it.bx;
            it.cy = it.by_coord;
        end
        return it;
    endfunction

    // input side: bursts with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready) begin
            totals_q.push_back(shade_triangle(in_if.data));
            beat_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || beat_taken) begin
            beat_taken = 1'b0;
            if (gap_left > 0 || triangle_q.size() == 0) begin
                if (gap_left > 0) gap_left--;
                in_if.valid <= 1'b0;
            end else begin
                in_if.data  <= triangle_q.pop_front();
                in_if.valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                end
            end
        end
    end

    // output side: stall runs alternating with ready runs
    always @(negedge i_clk) begin
        if (run_left > 0) begin
            run_left--;
            out_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_if.ready <= 1'b0;
        end else begin
            run_left   = $urandom_range(1, 30);
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        tor_pkg::t_out_item want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (totals_q.size() == 0) begin
                n_fail++;
                if (n_fail <= 10) $display("unexpected beat: %p", out_if.data);
            end else begin
                want = totals_q.pop_front();
                if (out_if.data.covered_total != want.covered_total ||
                    out_if.data.shaded_total != want.shaded_total ||
                    out_if.data.passed_here != want.passed_here ||
                    out_if.data.back_layer != want.back_layer) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("mismatch: expected %p, got %p", want, out_if.data);
                end
            end
        end
    end

    initial begin
        tor_pkg::t_in_item it;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        n_fail       = 0;
        beat_taken   = 1'b0;
        gap_left     = 0;
        burst_left   = 0;
        stall_left   = 0;
        run_left     = 0;
        covered_sum  = 0;
        shaded_sum   = 0;
        for (int i = 0; i < NPIX; i++) begin
            depth_mem[i] = 0;
            hits_mem[i]  = 0;
        end

        // right triangle on pixel corners, both windings, for the fill rule
        triangle_q.push_back(tor_tb_pkg::make_tri(0, 0, 0, 32, 0, 0, 0, 32, 0));
        triangle_q.push_back(tor_tb_pkg::make_tri(0, 0, 100, 0, 32, 100, 32, 0, 100));
        triangle_q.push_back(tor_tb_pkg::make_tri(0, 0, 100, 0, 32, 100, 32, 0, 100));
        triangle_q.push_back(tor_tb_pkg::make_tri(16, 16, 1000, 80, 20, 5000, 30, 70, 300));
        triangle_q.push_back(tor_tb_pkg::make_tri(16, 16, 33554431, 30, 70, 0,
                                                  80, 20, 33554431));
        triangle_q.push_back(tor_tb_pkg::make_tri(16, 16, 33554431, 80, 20, 33554431,
                                                  30, 70, 33554431));
        // degenerate: collinear along a pixel row
        triangle_q.push_back(tor_tb_pkg::make_tri(0, 48, 7, 40, 48, 9, 80, 48, 11));
        triangle_q.push_back(tor_tb_pkg::make_tri(5, 5, 500, 5, 5, 600, 5, 5, 700));
        // clipped at the far corner of the view
        triangle_q.push_back(tor_tb_pkg::make_tri(4060, 4060, 200, 4096, 4060, 300,
                                                  4060, 4096, 400));
        triangle_q.push_back(tor_tb_pkg::make_tri(4096, 4096, 16777216, 4070, 4096, 0,
                                                  4096, 4070, 1));
        triangle_q.push_back(tor_tb_pkg::make_tri(8191, 8191, 33554431, 8191, 8191,
                                                  33554431, 8191, 8191, 33554431));
        triangle_q.push_back(tor_tb_pkg::make_tri(8191, 0, 0, 4100, 8191, 1, 6000, 3000, 2));
        it = tor_tb_pkg::make_tri(1, 2, 3, 4, 5, 6, 7, 8, 9);
        it.action = tor_pkg::ACT_NONE;
        triangle_q.push_back(it);
        it.action = tor_pkg::ACT_CLEAR;
        triangle_q.push_back(it);
        triangle_q.push_back(tor_tb_pkg::make_tri(0, 0, 0, 32, 0, 0, 0, 32, 0));
        it.action = tor_pkg::ACT_CLEAR_ALL;
        triangle_q.push_back(it);
        triangle_q.push_back(tor_tb_pkg::make_tri(3, 7, 40, 60, 11, 90, 20, 50, 10));

        for (int i = 0; i < NRAND; i++) begin
            if (i == 700 || i == 1200) begin
                it = random_triangle();
                it.action = (i == 700) ? tor_pkg::ACT_CLEAR : tor_pkg::ACT_CLEAR_ALL;
            end else if ($urandom_range(0, 49) == 0) begin
                it = random_triangle();
                it.action = tor_pkg::ACT_NONE;
            end else begin
                it = random_triangle();
            end
            triangle_q.push_back(it);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (triangle_q.size() != 0 || in_if.valid || totals_q.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #100000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
